@@ hw/rtl/tlwd_pkg.sv @@
// Package with sizes, byte classes and the queue item type of the text line wrapper.
package tlwd_pkg;

    localparam int MAX_ROWS        = 256;
    localparam int ROW_COLUMNS     = 64;
    localparam int MAX_INPUT_BYTES = 16384;

    // Fixed field widths of the result beat.
    localparam int ROW_INDEX_W  = 8;
    localparam int COL_INDEX_W  = 6;
    localparam int LINE_COUNT_W = 9;
    localparam int WIDTH_W      = 7;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(48);

    // Internal state widths: the row reaches MAX_ROWS on the last break,
    // the column reaches the full row width.
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(ROW_COLUMNS + 1);
    localparam int CNT_W = $clog2(MAX_INPUT_BYTES + 2);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_ASCII = 8'd127;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_BREAK,
        CLS_NARROW,
        CLS_WIDE
    } byte_class_t;

    typedef struct packed {
        logic        first_byte;
        logic [7:0]  char_byte;
        byte_class_t cls;
    } item_t;

endpackage

@@ hw/rtl/tlwd_if.sv @@
// Handshake interfaces for the text byte channel and the buffer write channel.
interface tlwd_in_if;
    logic       valid;
    logic       ready;
    logic       first_byte;
    logic [7:0] char_byte;

    modport source (output valid, output first_byte, output char_byte, input ready);
    modport sink (input valid, input first_byte, input char_byte, output ready);
endinterface

interface tlwd_out_if;
    logic       valid;
    logic       ready;
    logic       write_valid;
    logic [7:0] row_index;
    logic [5:0] column_index;
    logic [7:0] out_byte;
    logic       text_done;
    logic [8:0] line_count;

    modport source (output valid, output write_valid, output row_index,
                    output column_index, output out_byte, output text_done,
                    output line_count, input ready);
    modport sink (input valid, input write_valid, input row_index,
                  input column_index, input out_byte, input text_done,
                  input line_count, output ready);
endinterface

@@ hw/rtl/tlwd_front.sv @@
// Front end: takes text beats and classifies each byte for the layout engine.
module tlwd_front
    import tlwd_pkg::*;
(
    tlwd_in_if.sink text_in,
    input  logic    queue_full,
    output logic    push,
    output item_t   push_item
);

    byte_class_t cls;

    always_comb
    begin
        if (text_in.char_byte == 8'd0)
        begin
            cls = CLS_ZERO;
        end
        else if (text_in.char_byte == BYTE_CR || text_in.char_byte == BYTE_LF)
        begin
            cls = CLS_BREAK;
        end
        else if (text_in.char_byte > BYTE_ASCII)
        begin
            cls = CLS_WIDE;
        end
        else
        begin
            cls = CLS_NARROW;
        end
    end

    assign text_in.ready        = !queue_full;
    assign push                 = text_in.valid && !queue_full;
    assign push_item.first_byte = text_in.first_byte;
    assign push_item.char_byte  = text_in.char_byte;
    assign push_item.cls        = cls;

endmodule

@@ hw/rtl/tlwd_queue.sv @@
// Short queue of classified bytes between the front end and the layout engine.
module tlwd_queue
    import tlwd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots_reg[rd_ptr_reg];

endmodule

@@ hw/rtl/tlwd_back.sv @@
// Layout engine: row and column tracking, wrapping, text end and the result register.
module tlwd_back
    import tlwd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WIDTH_W-1:0] cfg_wdata,
    input  logic               head_valid,
    input  item_t              head_item,
    output logic               pop,
    tlwd_out_if.source         result_out
);

    logic [WIDTH_W-1:0] width_reg;

    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic                   skip_reg, skip_next;
    logic                   trail_reg, trail_next;
    logic [COL_INDEX_W-1:0] tcol_reg, tcol_next;
    logic                   fin_reg, fin_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                    out_valid_reg;
    logic                    wr_reg, wr_next;
    logic [ROW_INDEX_W-1:0]  wrow_reg, wrow_next;
    logic [COL_INDEX_W-1:0]  wcol_reg, wcol_next;
    logic [7:0]              wbyte_reg, wbyte_next;
    logic                    done_reg, done_next;
    logic [LINE_COUNT_W-1:0] count_reg, count_next;

    logic [COL_W-1:0] eff_width;
    logic [COL_W-1:0] limit;
    logic             is_wide;

    assign pop = head_valid && (!out_valid_reg || result_out.ready);

    // Clamp the configured width into the range the buffer supports.
    always_comb
    begin
        if (COL_W'(width_reg) < COL_W'(2))
        begin
            eff_width = COL_W'(2);
        end
        else if (COL_W'(width_reg) > COL_W'(ROW_COLUMNS))
        begin
            eff_width = COL_W'(ROW_COLUMNS);
        end
        else
        begin
            eff_width = COL_W'(width_reg);
        end
    end

    assign is_wide = (head_item.cls == CLS_WIDE);
    assign limit   = is_wide ? eff_width - 1'b1 : eff_width;

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        skip_next  = skip_reg;
        trail_next = trail_reg;
        tcol_next  = tcol_reg;
        fin_next   = fin_reg;
        cnt_next   = cnt_reg;
        wr_next    = 1'b0;
        wrow_next  = '0;
        wcol_next  = '0;
        wbyte_next = '0;
        done_next  = 1'b0;
        count_next = '0;

        if (head_item.first_byte)
        begin
            row_next   = '0;
            col_next   = '0;
            skip_next  = 1'b0;
            trail_next = 1'b0;
            tcol_next  = '0;
            fin_next   = 1'b0;
            cnt_next   = '0;
        end

        if (!fin_next)
        begin
            cnt_next = cnt_next + 1'b1;
            if (trail_next)
            begin
                // The trail byte goes beside its lead byte, whatever its value.
                trail_next = 1'b0;
                wr_next    = 1'b1;
                wrow_next  = ROW_INDEX_W'(row_next);
                wcol_next  = tcol_next;
                wbyte_next = head_item.char_byte;
            end
            else if (skip_next)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                unique case (head_item.cls)
                    CLS_ZERO:
                    begin
                        done_next  = 1'b1;
                        count_next = LINE_COUNT_W'(row_next + 1'b1);
                    end
                    CLS_BREAK:
                    begin
                        row_next = row_next + 1'b1;
                        col_next = '0;
                        if (row_next >= ROW_W'(MAX_ROWS))
                        begin
                            done_next  = 1'b1;
                            count_next = LINE_COUNT_W'(MAX_ROWS);
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                    CLS_NARROW, CLS_WIDE:
                    begin
                        if (col_next >= limit)
                        begin
                            row_next = row_next + 1'b1;
                            col_next = '0;
                        end
                        if (row_next >= ROW_W'(MAX_ROWS))
                        begin
                            done_next  = 1'b1;
                            count_next = LINE_COUNT_W'(MAX_ROWS);
                        end
                        else
                        begin
                            wr_next    = 1'b1;
                            wrow_next  = ROW_INDEX_W'(row_next);
                            wcol_next  = COL_INDEX_W'(col_next);
                            wbyte_next = head_item.char_byte;
                            if (is_wide)
                            begin
                                trail_next = 1'b1;
                                tcol_next  = COL_INDEX_W'(col_next + 1'b1);
                                col_next   = col_next + COL_W'(2);
                            end
                            else
                            begin
                                col_next = col_next + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end

            // The byte limit waits until a pending trail byte has been placed.
            if (!done_next && !trail_next && cnt_next >= CNT_W'(MAX_INPUT_BYTES))
            begin
                done_next  = 1'b1;
                count_next = LINE_COUNT_W'(row_next + 1'b1);
            end

            if (done_next)
            begin
                fin_next   = 1'b1;
                skip_next  = 1'b0;
                trail_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            skip_reg      <= 1'b0;
            trail_reg     <= 1'b0;
            tcol_reg      <= '0;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end
            if (pop)
            begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                skip_reg  <= skip_next;
                trail_reg <= trail_next;
                tcol_reg  <= tcol_next;
                fin_reg   <= fin_next;
                cnt_reg   <= cnt_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            wr_reg    <= wr_next;
            wrow_reg  <= wrow_next;
            wcol_reg  <= wcol_next;
            wbyte_reg <= wbyte_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.write_valid  = wr_reg;
    assign result_out.row_index    = wrow_reg;
    assign result_out.column_index = wcol_reg;
    assign result_out.out_byte     = wbyte_reg;
    assign result_out.text_done    = done_reg;
    assign result_out.line_count   = count_reg;

    // A finished text stays silent until a new text starts.
    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop && fin_reg && !head_item.first_byte |=> !wr_reg && !done_reg)
        else $error("result produced after the text ended");

    // The column never runs past the widest row.
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(ROW_COLUMNS))
        else $error("column beyond the row width");

    // A trail byte and a swallowed byte are never both expected.
    a_trail_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(trail_reg && skip_reg))
        else $error("trail and skip pending together");

    // Once the text has ended nothing is left pending.
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !trail_reg && !skip_reg)
        else $error("pending byte after the text ended");

endmodule

@@ hw/rtl/text_line_wrap_dbcs_top.sv @@
// Top level of the text line wrapper for mixed single-byte and double-byte text.
//
//  Channel      Direction  Beat contents
//  text_in      in         first_byte, char_byte
//  result_out   out        write_valid, row_index, column_index, out_byte,
//                          text_done, line_count
//  cfg_we/wdata in         line_width (no read-back)
//
// One byte is taken per cycle while the queue is not full, and every byte yields
// exactly one result beat. A byte passes through the four-entry queue and then
// the result register before its result appears.
// The position update in the layout engine is combinational, which sets the
// sustained rate of one byte per clock while the result channel is not stalled.
// Reset clears the position state, the queue and the valid flag of the result
// register, and loads the line width with 48.
// A stalled result holds while the queue keeps taking bytes until it is full.
module text_line_wrap_dbcs_top
    import tlwd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tlwd_in_if.sink            text_in,
    tlwd_out_if.source         result_out,
    input  logic               cfg_we,
    input  logic [WIDTH_W-1:0] cfg_wdata
);

    // Classified bytes flow from the front end into the queue.
    logic  push;
    item_t push_item;
    logic  queue_full;

    // The layout engine pops a byte whenever its result register can take one.
    logic  pop;
    logic  head_valid;
    item_t head_item;

    tlwd_front u_front (
        .text_in    (text_in),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    tlwd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The engine holds the line width register and all position state.
    tlwd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule
